### design/bitmap_frame_allocator_top_defines.svh
// assertion macros used by the checker file
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// clocked property, ignored while reset is active
`define BFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bitmap frame allocator assertion failed");

// same, with a message of its own
`define BFA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

### design/bfa_pkg.sv
package bfa_pkg;

  // request codes
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  // result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_e;

  // field widths of the channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned START_W  = 20;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AADDR_W  = 25;
  localparam int unsigned FREE_W   = 14;
  localparam int unsigned RES_W    = 14;
  localparam int unsigned SUM_W    = 21;

  localparam logic [RES_W-1:0] RESERVED_RESET = 14'h100;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic sweep;
    logic rd;
    logic check;
    logic advance;
    logic publish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic at_last;
    logic hit;
    logic skip;
    logic out_busy;
    cmd_e cmd;
  } dp_stat_t;

  // index of the lowest zero bit of a word
  function automatic logic [4:0] first_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

### design/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cmd_e     in_cmd_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register, starts with the map clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.at_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_cmd_i)
            CMD_ALLOC: state_d = S_READ;
            CMD_FREE:  state_d = stat_i.skip ? S_RESULT : S_READ;
            CMD_MARK:  state_d = stat_i.skip ? S_RESULT : S_READ;
            CMD_INIT:  state_d = S_SWEEP;
            default:   state_d = S_RESULT;
          endcase
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.at_last) state_d = S_RESULT;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_RESULT;
        case (stat_i.cmd)
          CMD_ALLOC: begin
            if (!stat_i.hit && !stat_i.at_last) begin
              cmd_o.advance = 1'b1;
              state_d       = S_READ;
            end
          end
          CMD_MARK: begin
            if (!stat_i.at_last) begin
              cmd_o.advance = 1'b1;
              state_d       = S_READ;
            end
          end
          default: ;
        endcase
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/bfa_datapath.sv
module bfa_datapath import bfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 8192,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [ADDR_W-1:0]   frame_address_i,
  input  logic [START_W-1:0]  range_start_i,
  input  logic [COUNT_W-1:0]  range_count_i,
  input  logic                cfg_valid_i,
  input  logic [RES_W-1:0]    cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [AADDR_W-1:0]  alloc_address_o,
  output logic [FREE_W-1:0]   free_count_o
);

  localparam int unsigned MAP_WORDS = (NUM_FRAMES + 31) / 32;
  localparam int unsigned WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CW        = $clog2(NUM_FRAMES + 1);
  localparam int unsigned TAIL      = NUM_FRAMES % 32;
  localparam int unsigned AW        = WIW + 5 + PAGE_SHIFT;
  localparam logic [31:0] TAIL_MASK = (TAIL == 0) ? 32'h0 : ~((32'h1 << TAIL) - 32'h1);
  localparam logic [WIW-1:0] LAST_WORD = WIW'(MAP_WORDS - 1);

  logic [31:0] map_mem [MAP_WORDS];

  logic [WIW-1:0]   ptr_q, ptr_d, last_q, last_d;
  logic [4:0]       off_q, off_d, end_off_q, end_off_d;
  logic             first_q, first_d;
  cmd_e             cmd_q, cmd_d;
  logic [CW-1:0]    lim_q, lim_d, used_q, used_d;
  logic [RES_W-1:0] reserved_q;
  status_e          res_status_q, res_status_d;
  logic [AADDR_W-1:0] res_addr_q, res_addr_d;
  logic             out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [AADDR_W-1:0]  out_addr_q;
  logic [FREE_W-1:0]   out_free_q;
  logic [31:0]      rdata_q;

  // request decode on the raw input fields
  logic [31:0]      free_frame;
  logic             free_ok;
  logic [SUM_W-1:0] range_sum, range_end, range_last;
  logic             range_empty;
  logic [CW-1:0]    init_lim;

  assign free_frame  = 32'(frame_address_i >> PAGE_SHIFT);
  assign free_ok     = (frame_address_i != '0) && (free_frame < 32'(NUM_FRAMES));
  assign range_sum   = SUM_W'(range_start_i) + SUM_W'(range_count_i);
  assign range_end   = (range_sum > SUM_W'(NUM_FRAMES)) ? SUM_W'(NUM_FRAMES) : range_sum;
  assign range_last  = range_end - SUM_W'(1);
  assign range_empty = SUM_W'(range_start_i) >= range_end;
  assign init_lim    = (32'(reserved_q) > 32'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                         : CW'(reserved_q);

  // word masks for the current pointer
  logic          at_last;
  logic [31:0]   init_mask, range_mask, alloc_word;
  logic [4:0]    lo_off, hi_off, alloc_idx;
  logic          alloc_hit, free_hit;
  logic [5:0]    new_cnt;
  logic [WIW+4:0] alloc_frame;
  logic [AW-1:0]  alloc_byte;

  assign at_last = (ptr_q == last_q);

  always_comb begin
    if (CW'(ptr_q) < (lim_q >> 5)) begin
      init_mask = '1;
    end else if (CW'(ptr_q) == (lim_q >> 5)) begin
      init_mask = (32'h1 << lim_q[4:0]) - 32'h1;
    end else begin
      init_mask = '0;
    end
  end

  assign lo_off     = first_q ? off_q : 5'd0;
  assign hi_off     = at_last ? end_off_q : 5'd31;
  assign range_mask = ({32{1'b1}} << lo_off) & ({32{1'b1}} >> (5'd31 - hi_off));
  assign new_cnt    = 6'($countones(range_mask & ~rdata_q));

  assign alloc_word  = rdata_q | ((ptr_q == LAST_WORD) ? TAIL_MASK : 32'h0);
  assign alloc_hit   = ~&alloc_word;
  assign alloc_idx   = first_zero(alloc_word);
  assign alloc_frame = {ptr_q, alloc_idx};
  assign alloc_byte  = AW'(alloc_frame) << PAGE_SHIFT;
  assign free_hit    = rdata_q[off_q];

  // map write port
  logic        wr_en;
  logic [31:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = init_mask;
    if (cmd_i.sweep) begin
      wr_en = 1'b1;
    end else if (cmd_i.check) begin
      case (cmd_q)
        CMD_ALLOC: begin
          wr_en   = alloc_hit;
          wr_data = rdata_q | (32'h1 << alloc_idx);
        end
        CMD_FREE: begin
          wr_en   = free_hit;
          wr_data = rdata_q & ~(32'h1 << off_q);
        end
        CMD_MARK: begin
          wr_en   = 1'b1;
          wr_data = rdata_q | range_mask;
        end
        default: ;
      endcase
    end
  end

  // map memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[ptr_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rdata_q <= map_mem[ptr_q];
  end

  // item state, pointer and used count
  always_comb begin
    ptr_d        = ptr_q;
    last_d       = last_q;
    off_d        = off_q;
    end_off_d    = end_off_q;
    first_d      = first_q;
    cmd_d        = cmd_q;
    lim_d        = lim_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    if (cmd_i.load) begin
      first_d      = 1'b1;
      res_addr_d   = '0;
      res_status_d = ST_DONE;
      cmd_d        = cmd_e'(command_i);
      case (cmd_e'(command_i))
        CMD_ALLOC: begin
          ptr_d        = '0;
          last_d       = LAST_WORD;
          res_status_d = ST_NOMEM;
        end
        CMD_FREE: begin
          ptr_d        = WIW'(free_frame >> 5);
          last_d       = WIW'(free_frame >> 5);
          off_d        = free_frame[4:0];
          res_status_d = ST_IGNORED;
        end
        CMD_MARK: begin
          ptr_d     = WIW'(range_start_i >> 5);
          last_d    = WIW'(range_last >> 5);
          off_d     = range_start_i[4:0];
          end_off_d = range_last[4:0];
        end
        CMD_INIT: begin
          ptr_d  = '0;
          last_d = LAST_WORD;
          lim_d  = init_lim;
          used_d = init_lim;
        end
        default: ;
      endcase
    end
    if (cmd_i.sweep || cmd_i.advance) begin
      ptr_d = ptr_q + WIW'(1);
    end
    if (cmd_i.advance) begin
      first_d = 1'b0;
    end
    if (cmd_i.check) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (alloc_hit) begin
            used_d       = used_q + CW'(1);
            res_status_d = ST_DONE;
            res_addr_d   = AADDR_W'(alloc_byte);
          end
        end
        CMD_FREE: begin
          if (free_hit) begin
            used_d       = used_q - CW'(1);
            res_status_d = ST_DONE;
          end
        end
        CMD_MARK: used_d = used_q + CW'(new_cnt);
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      last_q      <= LAST_WORD;
      first_q     <= 1'b0;
      cmd_q       <= CMD_ALLOC;
      lim_q       <= '0;
      used_q      <= '0;
      reserved_q  <= RESERVED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      last_q  <= last_d;
      first_q <= first_d;
      cmd_q   <= cmd_d;
      lim_q   <= lim_d;
      used_q  <= used_d;
      if (cfg_valid_i) reserved_q <= cfg_data_i;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    end_off_q    <= end_off_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_free_q   <= FREE_W'(CW'(NUM_FRAMES) - used_q);
    end
  end

  assign stat_o.at_last  = at_last;
  assign stat_o.hit      = (cmd_q == CMD_ALLOC) ? alloc_hit : free_hit;
  assign stat_o.skip     = ((cmd_e'(command_i) == CMD_FREE) && !free_ok) ||
                           ((cmd_e'(command_i) == CMD_MARK) && range_empty);
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign stat_o.cmd      = cmd_q;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign alloc_address_o = out_addr_q;
  assign free_count_o    = out_free_q;

endmodule

### design/bitmap_frame_allocator_top.sv
// channel   direction  handshake              payload
// in        input      in_valid_i / in_stall_o  command, frame_address, range_start, range_count
// out       output     out_valid_o / out_stall_i status, alloc_address, free_count
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (reserved_frames)
//
// after reset a clearing pass writes each map word once before the first request
// transfer; cfg writes are taken at any time.
// allocate: reads and checks map words from word zero up to the first with a free frame;
// free: reads and checks one map word; mark range: each map word the range touches; init: a
// write to every map word. a free or mark rejected on its fields alone skips the map port.
// a stalled result waits in the output register; the next request runs up to its publish.
module bitmap_frame_allocator_top import bfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 8192,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [ADDR_W-1:0]   frame_address_i,
  input  logic [START_W-1:0]  range_start_i,
  input  logic [COUNT_W-1:0]  range_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [AADDR_W-1:0]  alloc_address_o,
  output logic [FREE_W-1:0]   free_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RES_W-1:0]    cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // the register write is always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_e'(command_i)),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // map, counters and result register
  bfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .command_i       (command_i),
    .frame_address_i (frame_address_i),
    .range_start_i   (range_start_i),
    .range_count_i   (range_count_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .free_count_o    (free_count_o)
  );

endmodule

### design/bfa_checker.sv
`include "bitmap_frame_allocator_top_defines.svh"

module bfa_checker import bfa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [AADDR_W-1:0]  alloc_address_o,
  input logic [FREE_W-1:0]   free_count_o
);

  // a request transfer makes the block busy on the next cycle
  `BFA_ASSERT(a_busy_after_in, in_valid_i && !in_stall_o |=> in_stall_o)

  // a stalled result holds
  `BFA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(alloc_address_o) && $stable(free_count_o))

  // out of memory leaves no free frame and no address
  `BFA_ASSERT_MSG(a_nomem_empty, out_valid_o && status_o == ST_NOMEM |-> alloc_address_o == '0 && free_count_o == '0, "out of memory with free frames left")

  // only defined result codes
  `BFA_ASSERT_MSG(a_status_code, out_valid_o |-> status_o == ST_DONE || status_o == ST_NOMEM || status_o == ST_IGNORED, "undefined result code")

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int unsigned MAP_FRAMES   = 8192;
  localparam int unsigned PAGE_SHIFT   = 12;
  localparam int unsigned MAP_WORDS    = MAP_FRAMES / 32;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned LONG_HOLD    = 1500;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  // one request transfer
  typedef struct packed {
    cmd_e                cmd;
    logic [ADDR_W-1:0]   addr;
    logic [START_W-1:0]  start;
    logic [COUNT_W-1:0]  count;
  } frame_req_t;

  // one result transfer
  typedef struct packed {
    status_e             status;
    logic [AADDR_W-1:0]  grant;
    logic [FREE_W-1:0]   free;
  } frame_reply_t;

  // shadow copy of the used map, predicts each result and checks it
  class frame_ledger;
    logic [31:0]        used_words [MAP_WORDS];
    int unsigned        used_total;
    logic [RES_W-1:0]   reserved;
    frame_reply_t       pending_replies [$];
    logic [ADDR_W-1:0]  granted [$];
    int unsigned        failures;

    function new();
      foreach (used_words[w]) used_words[w] = '0;
      used_total = 0;
      reserved   = RESERVED_RESET;
      failures   = 0;
    endfunction

    // frames past the map end read as used
    function bit frame_taken(int unsigned f);
      if (f >= MAP_FRAMES) return 1'b1;
      return used_words[f >> 5][f & 31];
    endfunction

    // set a range clipped at the map end, count only new bits
    function void take_run(int unsigned first, int unsigned n);
      for (int unsigned i = 0; i < n && first + i < MAP_FRAMES; i++) begin
        if (!frame_taken(first + i)) begin
          used_words[(first + i) >> 5][(first + i) & 31] = 1'b1;
          used_total++;
        end
      end
    endfunction

    function frame_reply_t apply_request(frame_req_t req);
      frame_reply_t r;
      int unsigned  f;
      r.status = ST_DONE;
      r.grant  = '0;
      case (req.cmd)
        CMD_ALLOC: begin
          // lowest free frame, skipping full words
          f = 0;
          while (f < MAP_FRAMES && frame_taken(f))
            f = (used_words[f >> 5] == '1) ? ((f | 31) + 1) : f + 1;
          if (f < MAP_FRAMES) begin
            used_words[f >> 5][f & 31] = 1'b1;
            used_total++;
            r.grant = AADDR_W'(f << PAGE_SHIFT);
            granted.push_back(ADDR_W'(f) << PAGE_SHIFT);
          end else begin
            r.status = ST_NOMEM;
          end
        end
        CMD_FREE: begin
          f = req.addr >> PAGE_SHIFT;
          if (req.addr == '0 || f >= MAP_FRAMES || !frame_taken(f)) begin
            r.status = ST_IGNORED;
          end else begin
            used_words[f >> 5][f & 31] = 1'b0;
            used_total--;
          end
        end
        CMD_MARK: take_run(req.start, req.count);
        default: begin
          foreach (used_words[w]) used_words[w] = '0;
          used_total = 0;
          granted.delete();
          take_run(0, reserved);
        end
      endcase
      r.free = FREE_W'(MAP_FRAMES - used_total);
      return r;
    endfunction

    function void note_request(frame_req_t req);
      pending_replies.push_back(apply_request(req));
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [AADDR_W-1:0] grant,
                              logic [FREE_W-1:0] free);
      frame_reply_t e;
      if (pending_replies.size() == 0) begin
        $error("result with no request outstanding: status %0d free %0d", status, free);
        failures++;
        return;
      end
      e = pending_replies.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        failures++;
      end
      if (grant !== e.grant) begin
        $error("alloc_address: expected %0h, got %0h", e.grant, grant);
        failures++;
      end
      if (free !== e.free) begin
        $error("free_count: expected %0d, got %0d", e.free, free);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    // hand back one previously allocated address at random
    function logic [ADDR_W-1:0] take_granted();
      int unsigned       k;
      logic [ADDR_W-1:0] a;
      k = $urandom_range(0, granted.size() - 1);
      a = granted[k];
      granted.delete(k);
      return a;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i;
  logic [ADDR_W-1:0]   frame_address_i;
  logic [START_W-1:0]  range_start_i;
  logic [COUNT_W-1:0]  range_count_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [AADDR_W-1:0]  alloc_address_o;
  logic [FREE_W-1:0]   free_count_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [RES_W-1:0]    cfg_data_i;

  frame_ledger     ledger = new();
  bit              hold_off_request = 1'b0;
  int unsigned     burst_left = 0;
  longint unsigned cycle_count = 0;

  bitmap_frame_allocator_top #(
    .NUM_FRAMES (MAP_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .frame_address_i (frame_address_i),
    .range_start_i   (range_start_i),
    .range_count_i   (range_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .free_count_o    (free_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result transfers go to the ledger
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_reply(status_o, alloc_address_o, free_count_o);
  end

  // receiver: stall patterns in segments, plus a long hold-off on request
  initial begin
    int unsigned seg_len, mode, stall_tick;
    stall_tick = 0;
    out_stall_i <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 300);
      repeat (seg_len) begin
        @(posedge clk_i);
        stall_tick++;
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          out_stall_i <= 1'b1;
          repeat (LONG_HOLD - 1) begin
            @(posedge clk_i);
            out_stall_i <= 1'b1;
          end
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ((stall_tick % 7) < 3);
          endcase
        end
      end
    end
  end

  // random filler for the fields a command does not use
  function automatic frame_req_t fresh_request(cmd_e c);
    frame_req_t req;
    req.cmd   = c;
    req.addr  = $urandom;
    req.start = START_W'($urandom_range(0, 20'hFFFFF));
    req.count = COUNT_W'($urandom_range(0, 14'h3FFF));
    return req;
  endfunction

  // mostly well-formed traffic with random content, some noise
  function automatic frame_req_t random_request();
    frame_req_t  req;
    int unsigned pick, lim;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      req = fresh_request(CMD_ALLOC);
    end else if (pick < 75) begin
      req = fresh_request(CMD_FREE);
      pick = $urandom_range(0, 99);
      lim = (ledger.reserved > MAP_FRAMES - 64) ? MAP_FRAMES - 1 : ledger.reserved + 63;
      if (pick < 55 && ledger.granted.size() > 0)
        req.addr = ledger.take_granted() | $urandom_range(0, 4095);
      else if (pick < 75)
        req.addr = ($urandom_range(0, lim) << PAGE_SHIFT) | $urandom_range(0, 4095);
      else if (pick < 85)
        req.addr = $urandom;
      else if (pick < 90)
        req.addr = '0;
      else
        req.addr = ((MAP_FRAMES + $urandom_range(0, 2047)) << PAGE_SHIFT)
                   | $urandom_range(0, 4095);
    end else if (pick < 96) begin
      req = fresh_request(CMD_MARK);
      pick = $urandom_range(0, 99);
      if (pick < 80)      req.start = START_W'($urandom_range(0, MAP_FRAMES - 1));
      else if (pick < 88) req.start = START_W'($urandom_range(MAP_FRAMES - 92, MAP_FRAMES - 1));
      else                req.start = START_W'($urandom_range(0, 20'hFFFFF));
      pick = $urandom_range(0, 99);
      if (pick < 85)      req.count = COUNT_W'($urandom_range(0, 48));
      else if (pick < 97) req.count = COUNT_W'($urandom_range(0, MAP_FRAMES));
      else                req.count = COUNT_W'($urandom_range(0, 14'h3FFF));
    end else begin
      req = fresh_request(CMD_INIT);
    end
    return req;
  endfunction

  // offer one request and hold it until the transfer
  task automatic send_request(frame_req_t req);
    in_valid_i      <= 1'b1;
    command_i       <= req.cmd;
    frame_address_i <= req.addr;
    range_start_i   <= req.start;
    range_count_i   <= req.count;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(req);
  endtask

  task automatic issue(cmd_e c, logic [ADDR_W-1:0] a, logic [START_W-1:0] s,
                       logic [COUNT_W-1:0] n);
    frame_req_t req;
    req = fresh_request(c);
    case (c)
      CMD_FREE: req.addr = a;
      CMD_MARK: begin
        req.start = s;
        req.count = n;
      end
      default: ;
    endcase
    send_request(req);
  endtask

  task automatic idle_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // bursts of random length with random gaps
  task automatic pace_sender(bit steady);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 9) >= 3) idle_sender($urandom_range(1, 8));
    end
  endtask

  task automatic wait_replies_drained();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reserved(logic [RES_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ledger.reserved = v;
  endtask

  // stimulus
  initial begin
    frame_req_t       req;
    int unsigned      sent, phase, phase_len, pick;
    logic [RES_W-1:0] res;
    bit               steady;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    command_i       <= CMD_ALLOC;
    frame_address_i <= '0;
    range_start_i   <= '0;
    range_count_i   <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default reservation, every command, ignored frees, clipped ranges
    issue(CMD_INIT, '0, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);
    issue(CMD_FREE, (32'd256 << PAGE_SHIFT) | 32'hABC, '0, '0);
    issue(CMD_FREE, (32'd256 << PAGE_SHIFT) | 32'hABC, '0, '0);
    issue(CMD_FREE, '0, '0, '0);
    issue(CMD_FREE, 32'hFFFF_FFFF, '0, '0);
    issue(CMD_FREE, 32'(MAP_FRAMES) << PAGE_SHIFT, '0, '0);
    issue(CMD_FREE, 32'hFFF, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);
    issue(CMD_MARK, '0, 20'(MAP_FRAMES - 2), 14'd5);
    issue(CMD_MARK, '0, 20'(MAP_FRAMES), 14'd100);
    issue(CMD_MARK, '0, 20'hFFFFF, 14'h3FFF);
    issue(CMD_MARK, '0, '0, '0);
    issue(CMD_MARK, '0, 20'd300, 14'd64);
    issue(CMD_FREE, 32'(MAP_FRAMES - 1) << PAGE_SHIFT, '0, '0);

    // full map, out-of-memory and recovery
    wait_replies_drained();
    write_reserved(14'(MAP_FRAMES));
    issue(CMD_INIT, '0, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);
    issue(CMD_FREE, 32'd4000 << PAGE_SHIFT, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);
    issue(CMD_ALLOC, '0, '0, '0);

    // reservation beyond the map is clipped
    wait_replies_drained();
    write_reserved(14'h3FFF);
    issue(CMD_INIT, '0, '0, '0);

    // empty reservation, then fill with one range
    wait_replies_drained();
    write_reserved('0);
    issue(CMD_INIT, '0, '0, '0);
    issue(CMD_MARK, '0, '0, 14'h3FFF);
    issue(CMD_ALLOC, '0, '0, '0);

    // random phases, each under its own reservation and opened by an init
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: res = '0;
        1: res = 14'(MAP_FRAMES);
        2: res = RESERVED_RESET;
        3: res = 14'h3FFF;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7)      res = RES_W'($urandom_range(0, 2048));
          else if (pick < 9) res = RES_W'($urandom_range(0, MAP_FRAMES));
          else               res = RES_W'($urandom_range(0, 14'h3FFF));
        end
      endcase
      wait_replies_drained();
      write_reserved(res);
      steady    = (phase % 4 == 2);
      phase_len = (res > MAP_FRAMES / 2) ? $urandom_range(40, 70) : $urandom_range(100, 260);
      burst_left = 0;
      send_request(fresh_request(CMD_INIT));
      sent++;
      if (phase == 4) hold_off_request = 1'b1;
      for (int unsigned k = 1; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (phase == 2 && k == phase_len / 2) wait_replies_drained();
        req = random_request();
        send_request(req);
        sent++;
        pace_sender(steady);
      end
      phase++;
    end

    // drain, then allow for a stray late result
    wait_replies_drained();
    repeat (600) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### bitmap_frame_allocator_top.f
+incdir+design
design/bfa_pkg.sv
design/bfa_ctrl.sv
design/bfa_datapath.sv
design/bitmap_frame_allocator_top.sv
design/bfa_checker.sv
test/tb.sv
